// ----- rtl/core/ptd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, constants and codes of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int MAX_TASKS      = 8;
    localparam int TASK_IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TASK_CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    localparam int CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEDULE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 1'd1;

    localparam logic [31:0] OVERFLOW_LIMIT_RST = 32'd100000;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_ADD       = 2'd1,
        OP_SET_STATE = 2'd2,
        OP_SHIFT     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_TICK_IGNORED = 3'd1,
        CMD_ADD          = 3'd2,
        CMD_SET_STATE    = 3'd3,
        CMD_SHIFT        = 3'd4
    } cmd_kind_t;

    typedef enum logic [2:0] {
        RES_DISPATCH     = 3'd0,
        RES_NONE_READY   = 3'd1,
        RES_ADDED        = 3'd2,
        RES_TABLE_FULL   = 3'd3,
        RES_TICK_IGNORED = 3'd4,
        RES_DONE         = 3'd5,
        RES_BAD_INDEX    = 3'd6
    } res_kind_t;

    typedef enum logic [1:0] {
        EX_IDLE  = 2'd0,
        EX_CALC  = 2'd1,
        EX_EVAL  = 2'd2,
        EX_FLUSH = 2'd3
    } exec_state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [31:0]        amount;
        logic [15:0]        interval;
        logic               run;
        logic signed [31:0] offset;
        logic [2:0]         sel;
    } cmd_t;

    typedef struct packed {
        res_kind_t          kind;
        logic [2:0]         task_index;
        logic signed [31:0] lateness;
        logic signed [31:0] worst_lateness;
        logic [31:0]        tick_count;
        logic               last;
    } res_t;

    typedef struct packed {
        logic schedule_mode;
    } sched_cfg_t;

endpackage

// ----- rtl/core/ptd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_front
// Holds the configuration registers, accepts input beats and classifies them
// into commands for the command queue.
// ----------------------------------------------------------------------------
module ptd_front
    import ptd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic [31:0]          tick_amount,
    input  logic [15:0]          interval,
    input  logic                 run_flag,
    input  logic signed [31:0]   offset,
    input  logic [2:0]           task_select,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 fifo_full,
    output logic                 cmd_wr,
    output cmd_t                 cmd,
    output sched_cfg_t           cfg
);

    logic        schedule_mode_reg;
    logic [31:0] overflow_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            schedule_mode_reg  <= 1'b0;
            overflow_limit_reg <= OVERFLOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCHEDULE_MODE:  schedule_mode_reg  <= cfg_wdata[0];
                CFG_OVERFLOW_LIMIT: overflow_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd.amount   = tick_amount;
        cmd.interval = interval;
        cmd.run      = run_flag;
        cmd.offset   = offset;
        cmd.sel      = task_select;
        case (opcode_t'(opcode))
            OP_TICK:      cmd.kind = (tick_amount > overflow_limit_reg) ? CMD_TICK_IGNORED
                                                                        : CMD_TICK;
            OP_ADD:       cmd.kind = CMD_ADD;
            OP_SET_STATE: cmd.kind = CMD_SET_STATE;
            OP_SHIFT:     cmd.kind = CMD_SHIFT;
            default:      cmd.kind = CMD_TICK_IGNORED;
        endcase
    end

    assign cmd_wr            = push && !fifo_full;
    assign full              = fifo_full;
    assign cfg.schedule_mode = schedule_mode_reg;

endmodule

// ----- rtl/core/ptd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_cmd_fifo
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module ptd_cmd_fifo
    import ptd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    output logic rd_valid,
    input  logic rd_en,
    output cmd_t rd_data
);

    cmd_t                 entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMD_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMD_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CMD_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/ptd_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_exec
// Executes commands against the task table, scans the slots on a tick and
// holds the result register seen on the output side.
// ----------------------------------------------------------------------------
module ptd_exec
    import ptd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  sched_cfg_t cfg,
    input  logic       pop,
    output logic       out_valid,
    output res_t       res
);

    localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SUM_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SUM_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    exec_state_t            state_reg;
    exec_state_t            state_next;

    logic [15:0]            period_reg  [MAX_TASKS];
    logic signed [31:0]     elapsed_reg [MAX_TASKS];
    logic                   running_reg [MAX_TASKS];
    logic signed [31:0]     worst_reg   [MAX_TASKS];

    logic [TASK_CNT_W-1:0]  task_count_reg;
    logic [TASK_CNT_W-1:0]  task_count_next;
    logic [31:0]            ticks_reg;
    logic [31:0]            ticks_next;
    logic [31:0]            amount_reg;
    logic [31:0]            amount_next;
    logic [TASK_CNT_W-1:0]  scan_reg;
    logic [TASK_CNT_W-1:0]  scan_next;
    logic signed [31:0]     sat_e_reg;
    logic signed [31:0]     sat_e_next;
    logic signed [33:0]     wp_reg;
    logic signed [33:0]     wp_next;
    logic                   run_cur_reg;
    logic                   run_cur_next;
    logic [15:0]            period_cur_reg;
    logic [15:0]            period_cur_next;
    logic                   dispatched_reg;
    logic                   dispatched_next;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    res_t                   pend_reg;
    res_t                   pend_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   out_reg;
    res_t                   out_next;

    logic                   out_free;
    logic                   emit;
    res_t                   emit_res;
    logic [TASK_IDX_W-1:0]  rd_idx;
    logic [TASK_IDX_W-1:0]  scan_idx;
    logic [TASK_IDX_W-1:0]  sel_idx;
    logic                   sel_bad;
    logic signed [31:0]     elapsed_cur;
    logic signed [31:0]     worst_cur;
    logic signed [33:0]     tick_sum;
    logic signed [33:0]     shift_sum;
    logic [TASK_CNT_W-1:0]  scan_inc;
    logic                   ready;
    logic                   advance;
    logic signed [31:0]     late;
    logic                   late_gt;

    logic                   we_period;
    logic                   we_elapsed;
    logic                   we_running;
    logic                   we_worst;
    logic [TASK_IDX_W-1:0]  wr_idx;
    logic signed [31:0]     wr_elapsed;
    logic                   wr_running;

    assign out_free    = !out_valid_reg || pop;
    assign scan_idx    = scan_reg[TASK_IDX_W-1:0];
    assign sel_idx     = TASK_IDX_W'(cmd.sel);
    assign sel_bad     = 32'(cmd.sel) >= 32'(task_count_reg);
    assign rd_idx      = (state_reg == EX_IDLE) ? sel_idx : scan_idx;
    assign elapsed_cur = elapsed_reg[rd_idx];
    assign worst_cur   = worst_reg[rd_idx];
    assign tick_sum    = {{2{elapsed_cur[31]}}, elapsed_cur} + $signed({2'b00, amount_reg});
    assign shift_sum   = {{2{elapsed_cur[31]}}, elapsed_cur}
                       + {{2{cmd.offset[31]}}, cmd.offset};
    assign scan_inc    = scan_reg + TASK_CNT_W'(1);

    // worst + period is formed a step early so lateness and its max test run side by side
    assign ready   = run_cur_reg && (sat_e_reg >= $signed({16'h0000, period_cur_reg}))
                   && !(cfg.schedule_mode && dispatched_reg);
    assign advance = !(ready && pend_valid_reg && !out_free);
    assign late    = sat_e_reg - $signed({16'h0000, period_cur_reg});
    assign late_gt = {{2{sat_e_reg[31]}}, sat_e_reg} > wp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_TICK))
                begin
                    state_next = (task_count_reg == '0) ? EX_FLUSH : EX_CALC;
                end
            end
            EX_CALC:
            begin
                state_next = EX_EVAL;
            end
            EX_EVAL:
            begin
                if (advance)
                begin
                    state_next = (scan_inc == task_count_reg) ? EX_FLUSH : EX_CALC;
                end
            end
            EX_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = EX_IDLE;
                end
            end
            default:
            begin
                state_next = EX_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        emit_res        = '{kind: RES_DONE, task_index: 3'd0, lateness: 32'sd0,
                            worst_lateness: 32'sd0, tick_count: ticks_reg, last: 1'b1};
        task_count_next = task_count_reg;
        ticks_next      = ticks_reg;
        amount_next     = amount_reg;
        scan_next       = scan_reg;
        sat_e_next      = sat_e_reg;
        wp_next         = wp_reg;
        run_cur_next    = run_cur_reg;
        period_cur_next = period_cur_reg;
        dispatched_next = dispatched_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        we_period       = 1'b0;
        we_elapsed      = 1'b0;
        we_running      = 1'b0;
        we_worst        = 1'b0;
        wr_idx          = rd_idx;
        wr_elapsed      = 32'sd0;
        wr_running      = cmd.run;

        case (state_reg)
            EX_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_TICK))
                begin
                    cmd_pop         = 1'b1;
                    amount_next     = cmd.amount;
                    ticks_next      = ticks_reg + 32'd1;
                    scan_next       = '0;
                    dispatched_next = 1'b0;
                    pend_valid_next = 1'b0;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    emit    = 1'b1;
                    case (cmd.kind)
                        CMD_TICK_IGNORED:
                        begin
                            emit_res.kind = RES_TICK_IGNORED;
                        end
                        CMD_ADD:
                        begin
                            if (task_count_reg < TASK_CNT_W'(MAX_TASKS))
                            begin
                                we_period       = 1'b1;
                                we_elapsed      = 1'b1;
                                we_running      = 1'b1;
                                wr_idx          = task_count_reg[TASK_IDX_W-1:0];
                                wr_elapsed      = cmd.offset;
                                task_count_next = task_count_reg + TASK_CNT_W'(1);
                                emit_res.kind       = RES_ADDED;
                                emit_res.task_index = 3'(task_count_reg);
                            end
                            else
                            begin
                                emit_res.kind = RES_TABLE_FULL;
                            end
                        end
                        CMD_SET_STATE, CMD_SHIFT:
                        begin
                            emit_res.task_index = cmd.sel;
                            if (sel_bad)
                            begin
                                emit_res.kind = RES_BAD_INDEX;
                            end
                            else
                            begin
                                we_elapsed    = 1'b1;
                                wr_idx        = sel_idx;
                                emit_res.kind = RES_DONE;
                                if (cmd.kind == CMD_SET_STATE)
                                begin
                                    we_running = 1'b1;
                                end
                                else
                                begin
                                    wr_elapsed = sat32(shift_sum);
                                end
                            end
                        end
                        default:
                        begin
                            emit_res.kind = RES_TICK_IGNORED;
                        end
                    endcase
                end
            end
            EX_CALC:
            begin
                run_cur_next    = running_reg[scan_idx];
                period_cur_next = period_reg[scan_idx];
                sat_e_next      = running_reg[scan_idx] ? sat32(tick_sum) : elapsed_cur;
                wp_next         = {{2{worst_cur[31]}}, worst_cur}
                                + $signed({18'h00000, period_reg[scan_idx]});
            end
            EX_EVAL:
            begin
                if (advance)
                begin
                    scan_next = scan_inc;
                    wr_idx    = scan_idx;
                    if (ready)
                    begin
                        we_elapsed      = 1'b1;
                        wr_elapsed      = 32'sd0;
                        we_worst        = late_gt;
                        dispatched_next = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: RES_DISPATCH, task_index: 3'(scan_reg),
                                            lateness: late,
                                            worst_lateness: late_gt ? late : worst_cur,
                                            tick_count: ticks_reg, last: 1'b0};
                        if (pend_valid_reg)
                        begin
                            emit     = 1'b1;
                            emit_res = pend_reg;
                        end
                    end
                    else if (run_cur_reg)
                    begin
                        we_elapsed = 1'b1;
                        wr_elapsed = sat_e_reg;
                    end
                end
            end
            EX_FLUSH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        emit_res      = pend_reg;
                        emit_res.last = 1'b1;
                    end
                    else
                    begin
                        emit_res.kind = RES_NONE_READY;
                    end
                end
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= EX_IDLE;
            task_count_reg <= '0;
            ticks_reg      <= '0;
            scan_reg       <= '0;
            dispatched_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            task_count_reg <= task_count_next;
            ticks_reg      <= ticks_next;
            scan_reg       <= scan_next;
            dispatched_reg <= dispatched_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg     <= amount_next;
        sat_e_reg      <= sat_e_next;
        wp_reg         <= wp_next;
        run_cur_reg    <= run_cur_next;
        period_cur_reg <= period_cur_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        if (we_period)
        begin
            period_reg[wr_idx] <= cmd.interval;
        end
        if (we_elapsed)
        begin
            elapsed_reg[wr_idx] <= wr_elapsed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                running_reg[i] <= 1'b0;
                worst_reg[i]   <= 32'sd0;
            end
        end
        else
        begin
            if (we_running)
            begin
                running_reg[wr_idx] <= wr_running;
            end
            if (we_worst)
            begin
                worst_reg[wr_idx] <= late;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result written while result register still occupied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count_reg <= TASK_CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EX_CALC || state_reg == EX_EVAL) |-> scan_reg < task_count_reg)
        else $error("scan index beyond task count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (task_count_reg == $past(task_count_reg)
               || task_count_reg == $past(task_count_reg) + TASK_CNT_W'(1)))
        else $error("task count moved by more than one");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EX_FLUSH && out_free) |=> (state_reg == EX_IDLE && !pend_valid_reg))
        else $error("final tick beat did not close the scan");

endmodule

// ----- rtl/core/periodic_task_dispatcher_top.sv -----
`timescale 1ns / 1ps
// Add, set-state, shift and ignored-tick beats give their single result, registered, when
// the back end is idle. An accepted tick scans the table in the back end: each slot needs
// an add step (EX_CALC) and a compare/update step (EX_EVAL), and EX_FLUSH ends the scan.
// Throughput: one non-tick beat per cycle while results are popped; ticks bound by the scan.
// Reset: asynchronous active low; clears task count, tick count, run flags, worst
// lateness, queues and config (schedule_mode 0, overflow_limit 100000).
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top
// Periodic task dispatcher: front classifier, command queue and task executor.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_top
    import ptd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic [31:0]          tick_amount,
    input  logic [15:0]          interval,
    input  logic                 run_flag,
    input  logic signed [31:0]   offset,
    input  logic [2:0]           task_select,
    output logic                 empty,
    input  logic                 pop,
    output logic [2:0]           kind,
    output logic [2:0]           task_index,
    output logic signed [31:0]   lateness,
    output logic signed [31:0]   worst_lateness,
    output logic [31:0]          tick_count,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    logic       fifo_full;
    logic       cmd_wr;
    cmd_t       cmd_in;
    cmd_t       cmd_out;
    logic       cmd_valid;
    logic       cmd_pop;
    sched_cfg_t cfg;
    logic       out_valid;
    res_t       res;

    ptd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .tick_amount (tick_amount),
        .interval    (interval),
        .run_flag    (run_flag),
        .offset      (offset),
        .task_select (task_select),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fifo_full   (fifo_full),
        .cmd_wr      (cmd_wr),
        .cmd         (cmd_in),
        .cfg         (cfg)
    );

    ptd_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_wr),
        .wr_data  (cmd_in),
        .full     (fifo_full),
        .rd_valid (cmd_valid),
        .rd_en    (cmd_pop),
        .rd_data  (cmd_out)
    );

    ptd_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .pop       (pop),
        .out_valid (out_valid),
        .res       (res)
    );

    assign empty          = !out_valid;
    assign kind           = res.kind;
    assign task_index     = res.task_index;
    assign lateness       = res.lateness;
    assign worst_lateness = res.worst_lateness;
    assign tick_count     = res.tick_count;
    assign last           = res.last;

endmodule
